// ===== hw/rtl/query_argument_extract_decode_core_defines.svh =====
// Assertion macros for the port-level checker of the query argument decoder.
// No dependencies; the macros expect signals named clock and reset in the using scope.
`ifndef QUERY_ARGUMENT_EXTRACT_DECODE_CORE_DEFINES_SVH
`define QUERY_ARGUMENT_EXTRACT_DECODE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QAED_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QAED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that stays active through reset.
`define QAED_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/qaed_pkg.sv =====
// Shared types and constants of the query argument extractor and decoder.
// No dependencies; used by every module of the block.
package qaed_pkg;

   localparam int unsigned KEY_MAX = 16;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic [7:0] out_count;
      logic       out_last;
   } rsp_entry_type;

   // Results of one accepted item: count, then entries in delivery order.
   typedef struct packed {
      logic [1:0]    n;
      rsp_entry_type e0;
      rsp_entry_type e1;
   } push_type;

   typedef struct packed {
      logic [4:0]   key_length;
      logic [127:0] key_bytes;
      logic [7:0]   max_out;
   } cfg_type;

endpackage

// ===== hw/rtl/qaed_scan.sv =====
// Scan state and combinational decode step for one query string character.
// Depends on qaed_pkg for the configuration and result types.
module qaed_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_char,
   input  logic              in_final,
   input  qaed_pkg::cfg_type cfg,
   output qaed_pkg::push_type push
);
   import qaed_pkg::*;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_MATCH,
      MODE_SKIP,
      MODE_VALUE,
      MODE_DONE
   } scan_mode_type;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;

   localparam logic [1:0] ESC_IDLE = 2'd0;
   localparam logic [1:0] ESC_HIGH = 2'd1;
   localparam logic [1:0] ESC_LOW  = 2'd2;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h57);
      end
      return v;
   endfunction

   scan_mode_type mode_ff, mode_in;
   logic [4:0]    key_index_ff, key_index_in;
   logic [1:0]    esc_phase_ff, esc_phase_in;
   logic [7:0]    esc_value_ff, esc_value_in;
   logic [7:0]    count_ff, count_in;

   logic          step_v, fin_v;
   rsp_entry_type step_e, fin_e;
   logic [4:0]    key_len;
   logic [4:0]    ki_cur;
   logic [7:0]    key_char;

   always_comb begin
      key_len  = (cfg.key_length > 5'(KEY_MAX)) ? 5'(KEY_MAX) : cfg.key_length;
      ki_cur   = (mode_ff == MODE_START) ? 5'd0 : key_index_ff;
      key_char = cfg.key_bytes[ki_cur[3:0] * 8 +: 8];

      mode_in      = mode_ff;
      key_index_in = key_index_ff;
      esc_phase_in = esc_phase_ff;
      esc_value_in = esc_value_ff;
      count_in     = count_ff;
      step_v       = 1'b0;
      step_e       = '{out_kind: KIND_BYTE, out_byte: 8'd0, out_count: 8'd0, out_last: 1'b0};
      fin_v        = 1'b0;
      fin_e        = '{out_kind: KIND_NONE, out_byte: 8'd0, out_count: 8'd0, out_last: 1'b0};

      case (mode_ff)
         MODE_START, MODE_MATCH: begin
            if (in_char == CHAR_NUL ||
                (mode_ff == MODE_START && (in_char == CHAR_LF || in_char == CHAR_CR))) begin
               step_v          = 1'b1;
               step_e.out_kind = KIND_NONE;
               mode_in         = MODE_DONE;
            end else if (ki_cur < key_len && in_char == key_char) begin
               key_index_in = ki_cur + 5'd1;
               mode_in      = MODE_MATCH;
            end else if (ki_cur >= key_len && in_char == CHAR_EQ) begin
               mode_in      = MODE_VALUE;
               key_index_in = ki_cur;
               esc_phase_in = ESC_IDLE;
               esc_value_in = 8'd0;
               count_in     = 8'd0;
            end else begin
               mode_in      = (in_char == CHAR_AMP) ? MODE_START : MODE_SKIP;
               key_index_in = 5'd0;
            end
         end
         MODE_SKIP: begin
            if (in_char == CHAR_NUL) begin
               step_v          = 1'b1;
               step_e.out_kind = KIND_NONE;
               mode_in         = MODE_DONE;
            end else if (in_char == CHAR_AMP) begin
               mode_in = MODE_START;
            end
         end
         MODE_VALUE: begin
            if (in_char == CHAR_NUL || in_char == CHAR_AMP) begin
               step_v           = 1'b1;
               step_e.out_kind  = KIND_DONE;
               step_e.out_count = count_ff;
               mode_in          = MODE_DONE;
            end else if (count_ff < cfg.max_out) begin
               // Once the cap is reached the rest of the value is swallowed.
               if (esc_phase_ff == ESC_HIGH) begin
                  esc_value_in = {hex_value(in_char), 4'd0};
                  esc_phase_in = ESC_LOW;
               end else if (esc_phase_ff == ESC_LOW) begin
                  esc_value_in    = esc_value_ff + {4'd0, hex_value(in_char)};
                  esc_phase_in    = ESC_IDLE;
                  step_v          = 1'b1;
                  step_e.out_byte = esc_value_ff + {4'd0, hex_value(in_char)};
                  count_in        = count_ff + 8'd1;
               end else if (in_char == CHAR_PCT) begin
                  esc_phase_in = ESC_HIGH;
               end else begin
                  step_v          = 1'b1;
                  step_e.out_byte = (in_char == CHAR_PLUS) ? CHAR_SPACE : in_char;
                  count_in        = count_ff + 8'd1;
               end
            end
         end
         default: begin
         end
      endcase

      if (in_final) begin
         if (mode_in == MODE_VALUE) begin
            fin_v           = 1'b1;
            fin_e.out_kind  = KIND_DONE;
            fin_e.out_count = count_in;
         end else if (mode_in != MODE_DONE) begin
            fin_v = 1'b1;
         end
         mode_in      = MODE_START;
         key_index_in = 5'd0;
         esc_phase_in = ESC_IDLE;
         esc_value_in = 8'd0;
         count_in     = 8'd0;
      end

      // Pack results in order; the last one produced by this item carries the flag.
      push.n  = accept ? ({1'b0, step_v} + {1'b0, fin_v}) : 2'd0;
      push.e0 = step_v ? step_e : fin_e;
      push.e0.out_last = !(step_v && fin_v);
      push.e1 = fin_e;
      push.e1.out_last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         key_index_ff <= 5'd0;
         esc_phase_ff <= ESC_IDLE;
         esc_value_ff <= 8'd0;
         count_ff     <= 8'd0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         key_index_ff <= key_index_in;
         esc_phase_ff <= esc_phase_in;
         esc_value_ff <= esc_value_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ===== hw/rtl/qaed_rsp_queue.sv =====
// Four-entry queue: up to two results in per cycle, one out on out_ready.
// Depends on qaed_pkg for the result entry and push group types.
module qaed_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  qaed_pkg::push_type      push,
   output logic                    space,
   output logic                    out_valid,
   input  logic                    out_ready,
   output qaed_pkg::rsp_entry_type out_entry
);
   import qaed_pkg::*;

   rsp_entry_type mem_ff [4];
   logic [1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [2:0]    count_ff, count_in;
   logic          pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // Room for the two results an item may produce.
   assign space     = (count_ff <= 3'd2);
   assign count_in  = count_ff + {1'b0, push.n} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push.n;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.n == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.e1;
      end
   end

endmodule

// ===== hw/rtl/query_argument_extract_decode_core.sv =====
// Top level of the query argument extractor and URL decoder.
// Depends on qaed_pkg, qaed_scan and qaed_rsp_queue.
//
// One query string character is taken per cycle while req_tready is high; its
// results enter a four-entry queue and drain one per cycle while rsp_tready is
// high. A character yields at most two results (a decoded byte and the closing
// report on the final character), so the queue only fills, and req_tready only
// drops, when the rsp side stalls or a string ends on a character that itself
// emits a byte. The user writes the key, key length and output cap through the
// csr port while the block is idle (not enforced); csr_ready is always high.
module query_argument_extract_decode_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_char[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], out_count[15:8]
   output logic [1:0]  rsp_tuser,   // out_kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);
   import qaed_pkg::*;

   localparam logic [7:0] CSR_KEY_LENGTH = 8'd0;
   localparam logic [7:0] CSR_KEY_LOW    = 8'd1;
   localparam logic [7:0] CSR_KEY_HIGH   = 8'd2;
   localparam logic [7:0] CSR_MAX_OUT    = 8'd3;

   logic [4:0]    key_length_ff;
   logic [63:0]   key_low_ff, key_high_ff;
   logic [7:0]    max_out_ff;
   cfg_type       cfg;
   push_type      push;
   rsp_entry_type head;
   logic          space;
   logic          accept;

   assign csr_ready = 1'b1;
   assign req_tready = space;
   assign accept = req_tvalid && req_tready;

   assign cfg.key_length = key_length_ff;
   assign cfg.key_bytes  = {key_high_ff, key_low_ff};
   assign cfg.max_out    = max_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= 5'd6;
         key_low_ff    <= 64'd0;
         key_high_ff   <= 64'd0;
         max_out_ff    <= 8'd100;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_LENGTH: key_length_ff <= csr_data[4:0];
            CSR_KEY_LOW:    key_low_ff    <= csr_data;
            CSR_KEY_HIGH:   key_high_ff   <= csr_data;
            CSR_MAX_OUT:    max_out_ff    <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   qaed_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_char  (req_tdata),
      .in_final (req_tlast),
      .cfg      (cfg),
      .push     (push)
   );

   qaed_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (head)
   );

   assign rsp_tdata = {head.out_count, head.out_byte};
   assign rsp_tuser = head.out_kind;
   assign rsp_tlast = head.out_last;

endmodule

// ===== hw/rtl/qaed_checker.sv =====
// Port-level checks of the query argument decoder, bound to its top level.
// Depends on qaed_pkg and query_argument_extract_decode_core_defines.svh.
`include "query_argument_extract_decode_core_defines.svh"

module qaed_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import qaed_pkg::*;

   // A stalled result item holds its contents.
   `QAED_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp item changed while stalled")

   // Completion and not-found reports always close the results of their item.
   `QAED_ASSERT_NOW(a_report_last, rsp_tvalid && rsp_tuser != KIND_BYTE, rsp_tlast, "report item without tlast")

   // Only the field that belongs to the kind may be nonzero.
   `QAED_ASSERT_NOW(a_field_zero, rsp_tvalid, (rsp_tuser == KIND_BYTE) ? (rsp_tdata[15:8] == 8'd0) : (rsp_tdata[7:0] == 8'd0), "unused rsp field nonzero")

   // Reset empties the result queue.
   `QAED_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid, "rsp valid right after reset")

endmodule

bind query_argument_extract_decode_core qaed_checker u_checker (.*);
